>>> src/rprr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rprr_pkg: shared types and constants for round-robin replica placement
// Table sizing, request and status codes, and the sequencer states.
// ----------------------------------------------------------------------------
package rprr_pkg;

  localparam int MAX_NODES = 256;
  localparam int COPIES    = 3;

  localparam int IDX_W     = $clog2(MAX_NODES);
  localparam int CNT_W     = $clog2(MAX_NODES + 1);
  localparam int COPY_W    = (COPIES > 1) ? $clog2(COPIES) : 1;
  localparam int ADDR_W    = 32;
  localparam int PORT_W    = 16;
  localparam int ENTRY_W   = ADDR_W + PORT_W;
  localparam int FUNC_W    = 3;
  localparam int STATUS_W  = 3;
  localparam int IO_IDX_W  = 8;

  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [COPY_W-1:0]  copy_idx_t;
  typedef logic [ENTRY_W-1:0] entry_t;

  localparam copy_idx_t COPY_LAST = copy_idx_t'(COPIES - 1);

  typedef enum logic [FUNC_W-1:0] {
    FN_REGISTER   = 3'd0,
    FN_MARK_DEAD  = 3'd1,
    FN_ALLOCATE   = 3'd2,
    FN_MARK_USED  = 3'd3,
    FN_PICK       = 3'd4,
    FN_CLEAR_USED = 3'd5
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_NEW     = 3'd0,
    ST_REVIVED = 3'd1,
    ST_ALIVE   = 3'd2,
    ST_FULL    = 3'd3,
    ST_FEW     = 3'd4,
    ST_NONE    = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REG,
    S_ALLOC,
    S_PICK,
    S_EMIT,
    S_SEND
  } state_t;

endpackage
`default_nettype wire

>>> src/rprr_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rprr_req_if: request channel
// Valid/ready handshake carrying one placement request per transaction.
// ----------------------------------------------------------------------------
interface rprr_req_if;
  import rprr_pkg::*;

  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [ADDR_W-1:0]   node_address;
  logic [PORT_W-1:0]   node_port;
  logic [IO_IDX_W-1:0] node_index;

  modport source (output valid, func, node_address, node_port, node_index, input ready);
  modport sink   (input valid, func, node_address, node_port, node_index, output ready);
endinterface
`default_nettype wire

>>> src/rprr_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rprr_rsp_if: result channel
// Valid/ready handshake carrying one placement result per transaction.
// ----------------------------------------------------------------------------
interface rprr_rsp_if;
  import rprr_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [IO_IDX_W-1:0] chosen_index;
  logic                last;

  modport source (output valid, status, chosen_index, last, input ready);
  modport sink   (input valid, status, chosen_index, last, output ready);
endinterface
`default_nettype wire

>>> src/rprr_node_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rprr_node_mem: node address/port table
// Single write port, single registered read port; contents undefined until
// written.
// ----------------------------------------------------------------------------
module rprr_node_mem (
  input  logic            clk,
  input  logic            wr_en,
  input  rprr_pkg::idx_t  wr_addr,
  input  rprr_pkg::entry_t wr_data,
  input  logic            rd_en,
  input  rprr_pkg::idx_t  rd_addr,
  output rprr_pkg::entry_t rd_data
);
  import rprr_pkg::*;

  entry_t mem [MAX_NODES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

>>> src/replica_placement_round_robin.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// replica_placement_round_robin: round-robin replica placement sequencer
// Node table with alive and used marks; one wrap-around index unit is
// stepped by a small sequencer to register, allocate and pick nodes.
// ----------------------------------------------------------------------------
// Mark dead, mark used, clear used and too-few refusals: result loaded from idle.
// Register: scans the table, one table entry read per cycle.
// Allocate: scans for COPIES alive nodes, then sends COPIES results;
// pick: scans for an alive, unused node; one index check per cycle.
// Throughput: one request at a time; ready returns after the last result.
// Reset: counts, pointer, alive and used marks clear at once; no sweep.
// ----------------------------------------------------------------------------
module replica_placement_round_robin (
  input logic        clk,
  input logic        rst,
  rprr_req_if.sink   req,
  rprr_rsp_if.source rsp
);
  import rprr_pkg::*;

  function automatic logic [IO_IDX_W-1:0] to_out_idx(idx_t i);
    logic [IDX_W+IO_IDX_W-1:0] w;
    w = (IDX_W + IO_IDX_W)'(i);
    return w[IO_IDX_W-1:0];
  endfunction

  state_t state, state_next;

  cnt_t node_count;
  cnt_t alive_count;
  idx_t start_pointer, sp_next;
  logic [MAX_NODES-1:0] alive_flags;
  logic [MAX_NODES-1:0] used_flags;

  idx_t      cur, cur_next;
  cnt_t      steps, steps_next;
  copy_idx_t copy_k, copy_k_next;
  copy_idx_t emit_k, emit_k_next;
  cnt_t      scan, scan_next;
  logic      cmp_valid, cmp_valid_next;
  idx_t      cmp_idx, cmp_idx_next;
  idx_t      ptr_adv, ptr_adv_next;
  idx_t      sel [COPIES];
  entry_t    lat_entry;

  status_t             out_status;
  logic [IO_IDX_W-1:0] out_index;
  logic                out_last;

  logic                latch_req, sel_wr, mem_wr, mem_rd;
  logic                alive_wr, alive_val, used_wr, used_val, used_wipe;
  idx_t                flag_idx;
  logic                nc_inc, ac_inc, ac_dec;
  logic                load_out;
  status_t             ld_status;
  logic [IO_IDX_W-1:0] ld_index;
  logic                ld_last;

  entry_t mem_q;
  logic   req_fire, rsp_fire;
  idx_t   sp_eff, adv_op, adv_out, in_idx, nc_idx;
  cnt_t   adv_sum;
  logic   in_range;
  logic [IDX_W+IO_IDX_W-1:0] in_idx_w;

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = (state == S_SEND);
  assign rsp.status       = out_status;
  assign rsp.chosen_index = out_index;
  assign rsp.last         = out_last;
  assign req_fire = req.valid && req.ready;
  assign rsp_fire = rsp.valid && rsp.ready;

  // Shared wrap-around index unit
  assign sp_eff  = (cnt_t'(start_pointer) < node_count) ? start_pointer : '0;
  assign adv_op  = (state == S_IDLE) ? sp_eff : cur;
  assign adv_sum = cnt_t'(adv_op) + cnt_t'(1);
  assign adv_out = (adv_sum >= node_count) ? '0 : adv_sum[IDX_W-1:0];

  assign in_idx_w = (IDX_W + IO_IDX_W)'(req.node_index);
  assign in_idx   = in_idx_w[IDX_W-1:0];
  assign in_range = (CNT_W + IO_IDX_W)'(req.node_index) < (CNT_W + IO_IDX_W)'(node_count);
  assign nc_idx   = node_count[IDX_W-1:0];

  rprr_node_mem u_mem (
    .clk     (clk),
    .wr_en   (mem_wr),
    .wr_addr (nc_idx),
    .wr_data (lat_entry),
    .rd_en   (mem_rd),
    .rd_addr (scan[IDX_W-1:0]),
    .rd_data (mem_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    cur_next       = cur;
    steps_next     = steps;
    copy_k_next    = copy_k;
    emit_k_next    = emit_k;
    scan_next      = scan;
    cmp_valid_next = cmp_valid;
    cmp_idx_next   = cmp_idx;
    ptr_adv_next   = ptr_adv;
    sp_next        = start_pointer;
    latch_req      = 1'b0;
    sel_wr         = 1'b0;
    mem_wr         = 1'b0;
    mem_rd         = 1'b0;
    alive_wr       = 1'b0;
    alive_val      = 1'b0;
    used_wr        = 1'b0;
    used_val       = 1'b0;
    used_wipe      = 1'b0;
    flag_idx       = cur;
    nc_inc         = 1'b0;
    ac_inc         = 1'b0;
    ac_dec         = 1'b0;
    load_out       = 1'b0;
    ld_status      = ST_NEW;
    ld_index       = '0;
    ld_last        = 1'b1;
    unique case (state)
      S_IDLE: begin
        if (req_fire) begin
          unique case (req.func)
            FN_REGISTER: begin
              latch_req      = 1'b1;
              scan_next      = '0;
              cmp_valid_next = 1'b0;
              state_next     = S_REG;
            end
            FN_MARK_DEAD: begin
              flag_idx = in_idx;
              if (in_range && alive_flags[in_idx]) begin
                alive_wr = 1'b1;
                ac_dec   = 1'b1;
              end
              load_out   = 1'b1;
              ld_index   = req.node_index;
              state_next = S_SEND;
            end
            FN_MARK_USED: begin
              flag_idx = in_idx;
              if (in_range) begin
                used_wr  = 1'b1;
                used_val = 1'b1;
              end
              load_out   = 1'b1;
              ld_index   = req.node_index;
              state_next = S_SEND;
            end
            FN_CLEAR_USED: begin
              used_wipe  = 1'b1;
              load_out   = 1'b1;
              state_next = S_SEND;
            end
            FN_ALLOCATE, FN_PICK: begin
              if (alive_count < cnt_t'(COPIES) || node_count == '0) begin
                load_out   = 1'b1;
                ld_status  = ST_FEW;
                state_next = S_SEND;
              end else begin
                cur_next     = sp_eff;
                steps_next   = '0;
                copy_k_next  = '0;
                ptr_adv_next = adv_out;
                state_next   = (req.func == FN_ALLOCATE) ? S_ALLOC : S_PICK;
              end
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_REG: begin
        if (cmp_valid && mem_q == lat_entry) begin
          flag_idx = cmp_idx;
          if (alive_flags[cmp_idx]) begin
            ld_status = ST_ALIVE;
          end else begin
            alive_wr  = 1'b1;
            alive_val = 1'b1;
            ac_inc    = 1'b1;
            ld_status = ST_REVIVED;
          end
          load_out   = 1'b1;
          ld_index   = to_out_idx(cmp_idx);
          state_next = S_SEND;
        end else if (scan < node_count) begin
          mem_rd         = 1'b1;
          cmp_valid_next = 1'b1;
          cmp_idx_next   = scan[IDX_W-1:0];
          scan_next      = scan + cnt_t'(1);
        end else if (cmp_valid) begin
          cmp_valid_next = 1'b0;
        end else begin
          if (node_count >= cnt_t'(MAX_NODES)) begin
            ld_status = ST_FULL;
          end else begin
            mem_wr    = 1'b1;
            flag_idx  = nc_idx;
            alive_wr  = 1'b1;
            alive_val = 1'b1;
            used_wr   = 1'b1;
            nc_inc    = 1'b1;
            ac_inc    = 1'b1;
            ld_index  = to_out_idx(nc_idx);
          end
          load_out   = 1'b1;
          state_next = S_SEND;
        end
      end
      S_ALLOC: begin
        if (alive_flags[cur]) begin
          sel_wr     = 1'b1;
          cur_next   = adv_out;
          steps_next = '0;
          if (copy_k == COPY_LAST) begin
            sp_next     = ptr_adv;
            emit_k_next = '0;
            state_next  = S_EMIT;
          end else begin
            copy_k_next = copy_k + copy_idx_t'(1);
          end
        end else if (steps == node_count) begin
          load_out   = 1'b1;
          ld_status  = ST_NONE;
          state_next = S_SEND;
        end else begin
          cur_next   = adv_out;
          steps_next = steps + cnt_t'(1);
        end
      end
      S_PICK: begin
        if (steps == node_count) begin
          load_out   = 1'b1;
          ld_status  = ST_NONE;
          state_next = S_SEND;
        end else if (alive_flags[cur] && !used_flags[cur]) begin
          used_wr    = 1'b1;
          used_val   = 1'b1;
          sp_next    = ptr_adv;
          load_out   = 1'b1;
          ld_index   = to_out_idx(cur);
          state_next = S_SEND;
        end else begin
          cur_next   = adv_out;
          steps_next = steps + cnt_t'(1);
        end
      end
      S_EMIT: begin
        load_out   = 1'b1;
        ld_index   = to_out_idx(sel[emit_k]);
        ld_last    = (emit_k == COPY_LAST);
        state_next = S_SEND;
      end
      S_SEND: begin
        if (rsp_fire) begin
          if (!out_last) begin
            emit_k_next = emit_k + copy_idx_t'(1);
            state_next  = S_EMIT;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count    <= '0;
      alive_count   <= '0;
      start_pointer <= '0;
      alive_flags   <= '0;
      used_flags    <= '0;
      cmp_valid     <= 1'b0;
    end else begin
      start_pointer <= sp_next;
      cmp_valid     <= cmp_valid_next;
      if (nc_inc) begin
        node_count <= node_count + cnt_t'(1);
      end
      if (ac_inc) begin
        alive_count <= alive_count + cnt_t'(1);
      end else if (ac_dec) begin
        alive_count <= alive_count - cnt_t'(1);
      end
      if (alive_wr) begin
        alive_flags[flag_idx] <= alive_val;
      end
      if (used_wipe) begin
        used_flags <= '0;
      end else if (used_wr) begin
        used_flags[flag_idx] <= used_val;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    cur     <= cur_next;
    steps   <= steps_next;
    copy_k  <= copy_k_next;
    emit_k  <= emit_k_next;
    scan    <= scan_next;
    cmp_idx <= cmp_idx_next;
    ptr_adv <= ptr_adv_next;
    if (latch_req) begin
      lat_entry <= {req.node_address, req.node_port};
    end
    if (sel_wr) begin
      sel[copy_k] <= cur;
    end
    if (load_out) begin
      out_status <= ld_status;
      out_index  <= ld_index;
      out_last   <= ld_last;
    end
  end

  a_alive_le_nodes: assert property (@(posedge clk) disable iff (rst)
    alive_count <= node_count)
    else $error("alive count exceeds node count");

  a_pointer_in_table: assert property (@(posedge clk) disable iff (rst)
    node_count != '0 |-> cnt_t'(start_pointer) < node_count)
    else $error("start pointer outside table");

  a_busy_while_sending: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !req.ready)
    else $error("request accepted while a result is pending");

  a_table_grows: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> node_count >= $past(node_count))
    else $error("node count decreased");

  a_scan_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == S_ALLOC || state == S_PICK) |-> steps <= node_count)
    else $error("scan ran past the table");

endmodule
`default_nettype wire

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: replica placement round-robin testbench
// A short table of directed requests runs first, then random requests over a
// small pool of nodes, then the table is filled to capacity. A behavioral
// copy of the node table predicts unlisted results, all checked in order.
// ----------------------------------------------------------------------------
module tb_top;
  import rprr_pkg::*;

  localparam logic [FUNC_W-1:0] FN_SPARE6 = 3'd6;
  localparam int N_DIRECTED   = 25;
  localparam int PHASE_ITEMS  = 60;
  localparam int DRAIN_CYCLES = COPIES * (MAX_NODES + 1) + 40;
  localparam int HOLD_CYCLES  = 400;

  typedef struct packed {
    status_t             st;
    logic [IO_IDX_W-1:0] ch;
    logic                last;
  } placement_t;

  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [ADDR_W-1:0]   addr;
    logic [PORT_W-1:0]   port;
    logic [IO_IDX_W-1:0] idx;
    logic                typed;
    status_t             st;
    logic [IO_IDX_W-1:0] ch;
  } stim_row_t;

  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    '{FN_ALLOCATE,   32'h0000_0000, 16'h0000, 8'd0,   1'b1, ST_FEW,     8'd0},
    '{FN_MARK_DEAD,  32'h0000_0000, 16'h0000, 8'd0,   1'b1, ST_NEW,     8'd0},
    '{FN_MARK_USED,  32'h0000_0000, 16'h0000, 8'd255, 1'b1, ST_NEW,     8'd255},
    '{FN_CLEAR_USED, 32'h0000_0000, 16'h0000, 8'd0,   1'b1, ST_NEW,     8'd0},
    '{FN_SPARE6,     32'hFFFF_FFFF, 16'hFFFF, 8'd255, 1'b0, ST_NEW,     8'd0},
    '{FN_REGISTER,   32'h0000_0000, 16'h0000, 8'd0,   1'b1, ST_NEW,     8'd0},
    '{FN_REGISTER,   32'hFFFF_FFFF, 16'hFFFF, 8'd0,   1'b1, ST_NEW,     8'd1},
    '{FN_REGISTER,   32'h0000_0000, 16'h0000, 8'd0,   1'b1, ST_ALIVE,   8'd0},
    '{FN_ALLOCATE,   32'h0000_0000, 16'h0000, 8'd0,   1'b1, ST_FEW,     8'd0},
    '{FN_REGISTER,   32'h8000_0001, 16'h8001, 8'd0,   1'b1, ST_NEW,     8'd2},
    '{FN_ALLOCATE,   32'h0000_0000, 16'h0000, 8'd0,   1'b0, ST_NEW,     8'd0},
    '{FN_ALLOCATE,   32'h0000_0000, 16'h0000, 8'd0,   1'b0, ST_NEW,     8'd0},
    '{FN_MARK_DEAD,  32'h0000_0000, 16'h0000, 8'd1,   1'b1, ST_NEW,     8'd1},
    '{FN_MARK_DEAD,  32'h0000_0000, 16'h0000, 8'd1,   1'b1, ST_NEW,     8'd1},
    '{FN_PICK,       32'h0000_0000, 16'h0000, 8'd0,   1'b1, ST_FEW,     8'd0},
    '{FN_REGISTER,   32'hFFFF_FFFF, 16'hFFFF, 8'd0,   1'b1, ST_REVIVED, 8'd1},
    '{FN_REGISTER,   32'h1234_5678, 16'h5A5A, 8'd0,   1'b1, ST_NEW,     8'd3},
    '{FN_MARK_DEAD,  32'h0000_0000, 16'h0000, 8'd1,   1'b1, ST_NEW,     8'd1},
    '{FN_ALLOCATE,   32'h0000_0000, 16'h0000, 8'd0,   1'b0, ST_NEW,     8'd0},
    '{FN_MARK_USED,  32'h0000_0000, 16'h0000, 8'd0,   1'b1, ST_NEW,     8'd0},
    '{FN_MARK_USED,  32'h0000_0000, 16'h0000, 8'd2,   1'b1, ST_NEW,     8'd2},
    '{FN_MARK_USED,  32'h0000_0000, 16'h0000, 8'd3,   1'b1, ST_NEW,     8'd3},
    '{FN_PICK,       32'h0000_0000, 16'h0000, 8'd0,   1'b1, ST_NONE,    8'd0},
    '{FN_CLEAR_USED, 32'h0000_0000, 16'h0000, 8'd0,   1'b1, ST_NEW,     8'd0},
    '{FN_PICK,       32'h0000_0000, 16'h0000, 8'd0,   1'b0, ST_NEW,     8'd0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic rx_hold;

  int src_idle_pct = 25;
  int rx_idle_pct  = 45;
  int reqs_taken   = 0;
  int errors       = 0;

  logic [ADDR_W-1:0]   addr_tab [MAX_NODES];
  logic [PORT_W-1:0]   port_tab [MAX_NODES];
  bit                  alive_tab [MAX_NODES];
  bit                  used_tab [MAX_NODES];
  int                  node_cnt;
  int                  alive_cnt;
  int                  rr_ptr;
  logic [ADDR_W+PORT_W-1:0] node_pool [$];
  placement_t          step_out [$];
  placement_t          placements_due [$];

  rprr_req_if req_ch ();
  rprr_rsp_if rsp_ch ();

  replica_placement_round_robin dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report_bad(input string what);
    errors++;
    if (errors <= 40)
      $display("tb_top: mismatch: %s", what);
  endtask

  function automatic int wrap_inc(input int i);
    return (i + 1 >= node_cnt) ? 0 : i + 1;
  endfunction

  task automatic note_result(input status_t st, input int i, input logic last);
    step_out.push_back('{st, IO_IDX_W'(i), last});
  endtask

  task automatic predict_placement(input logic [FUNC_W-1:0] f, input logic [ADDR_W-1:0] a,
                                   input logic [PORT_W-1:0] p, input logic [IO_IDX_W-1:0] x);
    int i, j, s, cur;
    int picked [COPIES];
    bit found;
    step_out.delete();
    case (f)
      FN_REGISTER: begin
        cur = -1;
        for (i = 0; i < node_cnt; i++)
          if (cur < 0 && addr_tab[i] == a && port_tab[i] == p) cur = i;
        if (cur >= 0) begin
          if (alive_tab[cur]) begin
            note_result(ST_ALIVE, cur, 1'b1);
          end else begin
            alive_tab[cur] = 1'b1;
            alive_cnt++;
            note_result(ST_REVIVED, cur, 1'b1);
          end
        end else if (node_cnt >= MAX_NODES) begin
          note_result(ST_FULL, 0, 1'b1);
        end else begin
          addr_tab[node_cnt]  = a;
          port_tab[node_cnt]  = p;
          alive_tab[node_cnt] = 1'b1;
          used_tab[node_cnt]  = 1'b0;
          note_result(ST_NEW, node_cnt, 1'b1);
          node_cnt++;
          alive_cnt++;
        end
      end
      FN_MARK_DEAD: begin
        if (x < node_cnt && alive_tab[x]) begin
          alive_tab[x] = 1'b0;
          alive_cnt--;
        end
        note_result(ST_NEW, x, 1'b1);
      end
      FN_ALLOCATE: begin
        if (alive_cnt < COPIES || node_cnt == 0) begin
          note_result(ST_FEW, 0, 1'b1);
        end else begin
          cur = (rr_ptr < node_cnt) ? rr_ptr : 0;
          found = 1'b1;
          for (j = 0; j < COPIES && found; j++) begin
            for (s = 0; s < node_cnt && !alive_tab[cur]; s++) cur = wrap_inc(cur);
            if (!alive_tab[cur]) begin
              found = 1'b0;
            end else begin
              picked[j] = cur;
              cur = wrap_inc(cur);
            end
          end
          if (!found) begin
            note_result(ST_NONE, 0, 1'b1);
          end else begin
            for (j = 0; j < COPIES; j++) note_result(ST_NEW, picked[j], j == COPIES - 1);
            rr_ptr = wrap_inc((rr_ptr < node_cnt) ? rr_ptr : 0);
          end
        end
      end
      FN_MARK_USED: begin
        if (x < node_cnt) used_tab[x] = 1'b1;
        note_result(ST_NEW, x, 1'b1);
      end
      FN_PICK: begin
        if (alive_cnt < COPIES || node_cnt == 0) begin
          note_result(ST_FEW, 0, 1'b1);
        end else begin
          cur = (rr_ptr < node_cnt) ? rr_ptr : 0;
          found = 1'b0;
          for (s = 0; s < node_cnt && !found; s++) begin
            if (alive_tab[cur] && !used_tab[cur]) found = 1'b1;
            else cur = wrap_inc(cur);
          end
          if (found) begin
            used_tab[cur] = 1'b1;
            rr_ptr = wrap_inc((rr_ptr < node_cnt) ? rr_ptr : 0);
            note_result(ST_NEW, cur, 1'b1);
          end else begin
            note_result(ST_NONE, 0, 1'b1);
          end
        end
      end
      FN_CLEAR_USED: begin
        foreach (used_tab[k]) used_tab[k] = 1'b0;
        note_result(ST_NEW, 0, 1'b1);
      end
      default: ;
    endcase
  endtask

  task automatic issue(input logic [FUNC_W-1:0] f, input logic [ADDR_W-1:0] a,
                       input logic [PORT_W-1:0] p, input logic [IO_IDX_W-1:0] x,
                       input logic typed, input status_t st, input logic [IO_IDX_W-1:0] ch);
    while ($urandom_range(99) < src_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.func         <= f;
    req_ch.node_address <= a;
    req_ch.node_port    <= p;
    req_ch.node_index   <= x;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    predict_placement(f, a, p, x);
    if (typed) begin
      placements_due.push_back('{st, ch, 1'b1});
    end else begin
      foreach (step_out[k]) placements_due.push_back(step_out[k]);
    end
    reqs_taken++;
  endtask

  task automatic random_request();
    int roll;
    logic [ADDR_W-1:0]   a;
    logic [PORT_W-1:0]   p;
    logic [IO_IDX_W-1:0] x;
    logic [FUNC_W-1:0]   f;
    a = $urandom;
    p = PORT_W'($urandom);
    x = IO_IDX_W'($urandom);
    if (node_cnt > 0 && $urandom_range(9) != 0) x = IO_IDX_W'($urandom_range(node_cnt - 1));
    roll = $urandom_range(99);
    if (roll < 30) begin
      f = FN_REGISTER;
      if (node_pool.size() > 0 && $urandom_range(1) == 1)
        {a, p} = node_pool[$urandom_range(node_pool.size() - 1)];
      else
        node_pool.push_back({a, p});
    end else if (roll < 42) begin
      f = FN_MARK_DEAD;
    end else if (roll < 60) begin
      f = FN_ALLOCATE;
    end else if (roll < 70) begin
      f = FN_MARK_USED;
    end else if (roll < 85) begin
      f = FN_PICK;
    end else if (roll < 92) begin
      f = FN_CLEAR_USED;
    end else begin
      // any code, the unused ones included
      f = FUNC_W'($urandom);
    end
    issue(f, a, p, x, 1'b0, ST_NEW, '0);
  endtask

  // receive, check in order, then pick next ready
  initial begin
    placement_t want;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid && rsp_ch.ready) begin
        if (placements_due.size() == 0) begin
          report_bad($sformatf("unexpected result status %0d index %0d last %0d",
                               rsp_ch.status, rsp_ch.chosen_index, rsp_ch.last));
        end else begin
          want = placements_due.pop_front();
          if (rsp_ch.status !== want.st)
            report_bad($sformatf("status %0d, want %0d", rsp_ch.status, want.st));
          if (rsp_ch.chosen_index !== want.ch)
            report_bad($sformatf("chosen_index %0d, want %0d", rsp_ch.chosen_index, want.ch));
          if (rsp_ch.last !== want.last)
            report_bad($sformatf("last %0d, want %0d", rsp_ch.last, want.last));
        end
      end
      rsp_ch.ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // hold off the result side so the request side backs up
  initial begin
    rx_hold <= 1'b0;
    wait (reqs_taken >= N_DIRECTED + PHASE_ITEMS / 2);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin
    #20000000;
    $display("tb_top: done, errors");
    $finish;
  end

  initial begin
    req_ch.valid        <= 1'b0;
    req_ch.func         <= '0;
    req_ch.node_address <= '0;
    req_ch.node_port    <= '0;
    req_ch.node_index   <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < N_DIRECTED; r++)
      issue(DIRECTED[r].func, DIRECTED[r].addr, DIRECTED[r].port, DIRECTED[r].idx,
            DIRECTED[r].typed, DIRECTED[r].st, DIRECTED[r].ch);

    repeat (PHASE_ITEMS) random_request();
    src_idle_pct = 45;
    rx_idle_pct  = 25;
    repeat (PHASE_ITEMS) random_request();
    src_idle_pct = 0;
    rx_idle_pct  = 0;
    repeat (PHASE_ITEMS) random_request();

    // fill the table, then keep going against a full table
    while (node_cnt < MAX_NODES)
      issue(FN_REGISTER, $urandom, PORT_W'($urandom), IO_IDX_W'($urandom), 1'b0, ST_NEW, '0);
    repeat (20) random_request();

    req_ch.valid <= 1'b0;
    while (placements_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

endmodule

>>> files.f
src/rprr_pkg.sv
src/rprr_req_if.sv
src/rprr_rsp_if.sv
src/rprr_node_mem.sv
src/replica_placement_round_robin.sv
dv/tb_top.sv
